[design/hlr_pkg.sv]
// ----------------------------------------------------------------------------
// hlr_pkg
// Shared types and constants for the histogram largest-rectangle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hlr_pkg;

  // Result area width and its saturation value
  localparam int unsigned AREA_W = 42;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a bar
    S_LPOP,   // left pass: compare top of stack with the new bar
    S_LWAIT,  // left pass: reload top of stack after a pop
    S_SRD,    // scan: read height and left bound of bar k
    S_SPOP,   // scan: compare top of stack with bar k
    S_SWAIT,  // scan: reload top of stack after a pop
    S_MUL,    // scan: multiply height by width
    S_CMP,    // scan: saturate and keep the maximum
    S_DONE    // hand the result to the output register and clear
  } state_t;

  // Control from the sequencer to the area unit
  typedef struct packed {
    logic mul_en;  // register height * width
    logic cmp_en;  // fold the product into the running maximum
    logic clear;   // restart the running maximum
  } area_ctl_t;

endpackage

`default_nettype wire

[design/histogram_largest_rectangle_unit.sv]
// In the left pass a stored bar is compared with the top of stack, with a
// reload after each pop. A last bar then starts the right-to-left scan: each
// stored bar is read, compared (with a reload per pop), multiplied and folded
// into the maximum, then the result is registered. Each pass pops a bar at
// most once; a result held by out_stall also holds off the next bar.
// Reset clears sequencer, counters, maximum and output valid; memories unswept.
// ----------------------------------------------------------------------------
// histogram_largest_rectangle_unit
// Largest rectangle in a histogram with a monotonic stack and one shared
// compare unit under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_largest_rectangle_unit import hlr_pkg::*; #(
  parameter int MAX_BARS    = 1024,
  parameter int HEIGHT_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       bar_height,
  input  wire logic              last_bar,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [AREA_W-1:0]      max_area,
  output logic                   overflowed
);

  localparam int IDXW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int CNTW = $clog2(MAX_BARS + 1);
  localparam int STW  = IDXW + HEIGHT_BITS;

  state_t state, state_next;

  logic [HEIGHT_BITS-1:0] cur_h;
  logic                   cur_last;
  logic [CNTW-1:0]        bar_count;
  logic [CNTW-1:0]        depth;
  logic [IDXW-1:0]        top_idx;
  logic [HEIGHT_BITS-1:0] top_h;
  logic [IDXW-1:0]        k;
  logic [CNTW-1:0]        wid;
  logic                   dropped;
  logic [HEIGHT_BITS-1:0] hm_q;
  logic [CNTW-1:0]        lm_q;
  logic [STW-1:0]         st_q;

  // Memories
  logic [HEIGHT_BITS-1:0] height_mem [MAX_BARS];
  logic [CNTW-1:0]        left_mem   [MAX_BARS];
  logic [STW-1:0]         stack_mem  [MAX_BARS];

  // Control strobes
  logic                   in_acc;
  logic                   full;
  logic                   pop_cond;
  logic                   lpush, spush, push, pop;
  logic                   scan_init;
  logic                   out_free;
  logic [HEIGHT_BITS-1:0] cmp_h;
  logic [CNTW-1:0]        dm1, dm2;
  logic [CNTW-1:0]        right;
  logic [CNTW-1:0]        left_val;
  logic [IDXW-1:0]        push_idx;
  logic [HEIGHT_BITS-1:0] push_h;
  logic [IDXW-1:0]        k_init;
  area_ctl_t              area_ctl;
  logic [AREA_W-1:0]      best;

  assign full     = (bar_count == CNTW'(MAX_BARS));
  assign out_free = !out_valid || !out_stall;
  assign dm1      = depth - CNTW'(1);
  assign dm2      = depth - CNTW'(2);

  // Shared compare: pop while the top is not strictly lower
  assign cmp_h    = (state == S_SPOP) ? hm_q : cur_h;
  assign pop_cond = (depth != '0) && (top_h >= cmp_h);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!full) state_next = S_LPOP;
          else if (last_bar) state_next = S_SRD;
        end
      end
      S_LPOP: begin
        if (pop_cond) state_next = S_LWAIT;
        else if (cur_last) state_next = S_SRD;
        else state_next = S_IDLE;
      end
      S_LWAIT: state_next = S_LPOP;
      S_SRD:   state_next = S_SPOP;
      S_SPOP:  state_next = pop_cond ? S_SWAIT : S_MUL;
      S_SWAIT: state_next = S_SPOP;
      S_MUL:   state_next = S_CMP;
      S_CMP:   state_next = (k == '0) ? S_DONE : S_SRD;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer outputs
  always_comb begin
    in_stall        = (state != S_IDLE);
    in_acc          = in_valid && (state == S_IDLE);
    lpush           = (state == S_LPOP) && !pop_cond;
    spush           = (state == S_SPOP) && !pop_cond;
    pop             = ((state == S_LPOP) || (state == S_SPOP)) && pop_cond;
    push            = lpush || spush;
    scan_init       = (lpush && cur_last) || (in_acc && full && last_bar);
    area_ctl.mul_en = (state == S_MUL);
    area_ctl.cmp_en = (state == S_CMP);
    area_ctl.clear  = (state == S_DONE) && out_free;
  end

  // Push operands and bounds
  always_comb begin
    push_idx = lpush ? bar_count[IDXW-1:0] : k;
    push_h   = lpush ? cur_h : hm_q;
    left_val = (depth == '0) ? '0 : CNTW'(top_idx) + CNTW'(1);
    right    = (depth == '0) ? bar_count : CNTW'(top_idx);
    k_init   = lpush ? bar_count[IDXW-1:0] : bar_count[IDXW-1:0] - IDXW'(1);
  end

  // Height and left-bound memories
  always_ff @(posedge clk) begin
    if (lpush) begin
      height_mem[bar_count[IDXW-1:0]] <= cur_h;
      left_mem[bar_count[IDXW-1:0]]   <= left_val;
    end
    if (state == S_SRD) begin
      hm_q <= height_mem[k];
      lm_q <= left_mem[k];
    end
  end

  // Stack memory: entries below the top, top kept in registers
  always_ff @(posedge clk) begin
    if (push && (depth != '0)) begin
      stack_mem[dm1[IDXW-1:0]] <= {top_idx, top_h};
    end
    if (pop) begin
      st_q <= stack_mem[dm2[IDXW-1:0]];
    end
  end

  // Top of stack
  always_ff @(posedge clk) begin
    if (push) begin
      top_idx <= push_idx;
      top_h   <= push_h;
    end else if ((state == S_LWAIT) || (state == S_SWAIT)) begin
      {top_idx, top_h} <= st_q;
    end
  end

  // Stack depth, bar count, drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      bar_count <= '0;
      dropped   <= 1'b0;
    end else begin
      if (scan_init || area_ctl.clear) depth <= '0;
      else if (pop) depth <= dm1;
      else if (push) depth <= depth + CNTW'(1);

      if (area_ctl.clear) bar_count <= '0;
      else if (lpush) bar_count <= bar_count + CNTW'(1);

      if (area_ctl.clear) dropped <= 1'b0;
      else if (in_acc && full) dropped <= 1'b1;
    end
  end

  // Input capture, scan index, width
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_h    <= bar_height[HEIGHT_BITS-1:0];
      cur_last <= last_bar;
    end
    if (scan_init) begin
      k <= k_init;
    end else if ((state == S_CMP) && (k != '0)) begin
      k <= k - IDXW'(1);
    end
    if (spush) begin
      wid <= right - lm_q;
    end
  end

  hlr_area #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .CNTW        (CNTW)
  ) u_area (
    .clk    (clk),
    .rst    (rst),
    .ctl    (area_ctl),
    .height (hm_q),
    .width  (wid),
    .best   (best)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (area_ctl.clear) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (area_ctl.clear) begin
      max_area   <= best;
      overflowed <= dropped;
    end
  end

endmodule

`default_nettype wire

[design/hlr_area.sv]
// ----------------------------------------------------------------------------
// hlr_area
// Registered multiplier with saturation and a running maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module hlr_area import hlr_pkg::*; #(
  parameter int HEIGHT_BITS = 32,
  parameter int CNTW        = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire area_ctl_t              ctl,
  input  wire logic [HEIGHT_BITS-1:0] height,
  input  wire logic [CNTW-1:0]        width,
  output logic      [AREA_W-1:0]      best
);

  localparam int PRODW = HEIGHT_BITS + CNTW;
  localparam int EXTW  = (PRODW > AREA_W) ? PRODW : AREA_W + 1;

  logic [PRODW-1:0]  prod;
  logic [EXTW-1:0]   prod_ext;
  logic [AREA_W-1:0] sat;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PRODW'(height) * PRODW'(width);
    end
  end

  // Saturate to the result width
  always_comb begin
    prod_ext = EXTW'(prod);
    sat = (prod_ext > EXTW'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];
  end

  // Running maximum
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best <= '0;
    end else if (ctl.cmp_en && (sat > best)) begin
      best <= sat;
    end
  end

endmodule

`default_nettype wire

[design/hlr_checker.sv]
// ----------------------------------------------------------------------------
// hlr_checker
// Port-level checks on the histogram largest-rectangle unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hlr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last_bar,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [41:0] max_area,
  input wire logic        overflowed
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_area) && $stable(overflowed))
    else $error("result changed while stalled");

  // Ready right after reset
  a_ready_after_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_stall)
    else $error("input stalled right after reset");

  // A final bar always starts work that blocks input
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_bar |=> in_stall)
    else $error("final bar did not start the scan");

  // A new result is only produced while input was blocked
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a scan");

endmodule

bind histogram_largest_rectangle_unit hlr_checker u_hlr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_bar   (last_bar),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .max_area   (max_area),
  .overflowed (overflowed)
);

`default_nettype wire

[tb/sv/tb_histogram_largest_rectangle_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_largest_rectangle_unit
// Streams histograms into the largest-rectangle unit and checks every result.
// A behavioral stack model predicts the largest area and the dropped-bar flag
// for each histogram. Directed cases cover extreme heights, equal heights,
// classic shapes and a full store with extra bars. Random histograms follow.
// ----------------------------------------------------------------------------
module tb_histogram_largest_rectangle_unit;
  import hlr_pkg::*;

  localparam int BAR_CAP     = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [AREA_W-1:0] area;
    logic              dropped;
  } rect_result_t;

  // Height patterns for random histograms
  typedef enum int {MIX_WIDE, MIX_LOW, MIX_TALL, MIX_BLEND} height_mix_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [31:0]       bar_height = '0;
  logic              last_bar   = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [AREA_W-1:0] max_area;
  logic              overflowed;

  // Predictor state for the histogram in flight
  logic [31:0]  hist_bars[$];
  logic         hist_dropped = 1'b0;
  rect_result_t expected_rects[$];
  rect_result_t oldest_rect;

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  stall_burst = 0;
  bit  idle_en     = 1'b1;

  histogram_largest_rectangle_unit #(
    .MAX_BARS    (BAR_CAP),
    .HEIGHT_BITS (32)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .bar_height (bar_height),
    .last_bar   (last_bar),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .max_area   (max_area),
    .overflowed (overflowed)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Largest rectangle over the stored bars, single pass with an index stack
  function automatic logic [AREA_W-1:0] largest_area();
    int unsigned pile[$];
    int unsigned n;
    int unsigned top;
    int unsigned lo;
    logic [63:0] best;
    logic [63:0] area;
    best = '0;
    n = hist_bars.size();
    for (int unsigned i = 0; i <= n; i++) begin
      // pop every bar not strictly lower than the current one
      while (pile.size() > 0 && (i == n || hist_bars[pile[$]] >= hist_bars[i])) begin
        top = pile.pop_back();
        lo = (pile.size() == 0) ? 0 : pile[$] + 1;
        area = 64'(hist_bars[top]) * 64'(i - lo);
        if (area > best) best = area;
      end
      if (i < n) pile.insert(pile.size(), i);
    end
    if (best > 64'(AREA_MAX)) best = 64'(AREA_MAX);
    return best[AREA_W-1:0];
  endfunction

  // Update the prediction for one accepted bar
  task automatic note_bar(input logic [31:0] h, input logic lst);
    rect_result_t r;
    if (hist_bars.size() < BAR_CAP) hist_bars.insert(hist_bars.size(), h);
    else hist_dropped = 1'b1;
    if (lst) begin
      r.area    = largest_area();
      r.dropped = hist_dropped;
      expected_rects.insert(expected_rects.size(), r);
      hist_bars.delete();
      hist_dropped = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("tb: mismatch on %s: got %0h, want %0h (cycle %0d)",
               what, got, want, cycle_count);
    mismatches++;
  endtask

  // Send one bar; entered and left at a falling edge
  task automatic send_bar(input logic [31:0] h, input logic lst);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    bar_height <= h;
    last_bar   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    note_bar(h, lst);
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_rects.size() != 0) @(negedge clk);
  endtask

  // Random receiver stall bursts
  always @(negedge clk) begin
    if (stall_burst > 0) begin
      out_stall   <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_stall   <= 1'b1;
      stall_burst <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rects.size() == 0) begin
        report_mismatch("unexpected result", 64'(max_area), '0);
      end else begin
        oldest_rect = expected_rects.pop_front();
        if (max_area !== oldest_rect.area)
          report_mismatch("max_area", 64'(max_area), 64'(oldest_rect.area));
        if (overflowed !== oldest_rect.dropped)
          report_mismatch("overflowed", 64'(overflowed), 64'(oldest_rect.dropped));
      end
    end
  end

  // One-bar histograms at the extremes and alternating bit patterns
  task automatic test_single_bars();
    send_bar(32'h0000_0000, 1'b1);
    send_bar(32'hFFFF_FFFF, 1'b1);
    send_bar(32'h0000_0001, 1'b1);
    send_bar(32'h8000_0000, 1'b1);
    send_bar(32'h5555_5555, 1'b1);
    send_bar(32'hAAAA_AAAA, 1'b1);
  endtask

  // Full-height bars and runs of equal heights
  task automatic test_equal_heights();
    repeat (2) send_bar(32'hFFFF_FFFF, 1'b0);
    send_bar(32'hFFFF_FFFF, 1'b1);
    repeat (3) send_bar(32'd5, 1'b0);
    send_bar(32'd5, 1'b1);
    send_bar(32'd0, 1'b0);
    send_bar(32'd3, 1'b0);
    send_bar(32'd0, 1'b1);
  endtask

  // Rising and valley shapes
  task automatic test_shapes();
    for (int i = 1; i <= 4; i++) send_bar(32'(i), 1'b0);
    send_bar(32'd5, 1'b1);
    send_bar(32'd2, 1'b0);
    send_bar(32'd1, 1'b0);
    send_bar(32'd5, 1'b0);
    send_bar(32'd6, 1'b0);
    send_bar(32'd2, 1'b0);
    send_bar(32'd3, 1'b1);
  endtask

  // Store filled with full-height bars (the largest possible area), then one
  // dropped bar and a dropped bar that ends the histogram
  task automatic test_too_many_bars();
    for (int i = 0; i < BAR_CAP + 2; i++)
      send_bar((i < BAR_CAP) ? 32'hFFFF_FFFF : $urandom(), i == BAR_CAP + 1);
  endtask

  // Random histograms, mostly short, with mixed height patterns
  task automatic test_random_histograms();
    int          sent;
    int          len;
    height_mix_t mix;
    logic [31:0] h;
    sent = 0;
    while (sent < 750) begin
      // quiet stretch in the middle, none at all near the end
      idle_en = (sent < 250) || (sent >= 350 && sent < 600);
      case ($urandom_range(0, 19))
        0:       len = 1;
        1, 2:    len = $urandom_range(13, 60);
        default: len = $urandom_range(2, 12);
      endcase
      mix = height_mix_t'($urandom_range(0, 3));
      for (int b = 0; b < len; b++) begin
        case (mix)
          MIX_WIDE: h = $urandom();
          MIX_LOW:  h = $urandom_range(0, 7);
          MIX_TALL: h = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default:  h = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3);
        endcase
        send_bar(h, b == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_bars();
    test_equal_heights();
    drain_results();
    test_shapes();
    test_too_many_bars();
    test_random_histograms();

    in_valid <= 1'b0;
    idle_en = 1'b0;
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && hist_bars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
